@@ rtl/ntfq_pkg.sv @@
`timescale 1ns / 1ps
package ntfq_pkg;

  localparam int unsigned DefDepth  = 16;
  localparam int unsigned TimeBits  = 48;
  localparam int unsigned SeqBits   = 32;
  localparam int unsigned HandleBits = 32;
  localparam int unsigned LimitBits = 5;

  localparam logic [LimitBits-1:0] LimitReset = LimitBits'(16);
  localparam logic [TimeBits-1:0]  TolReset   = TimeBits'(10000);

  // Request kinds carried on the input tuser
  typedef enum logic [1:0] {
    REQ_PUSH    = 2'd0,
    REQ_TAKE_NR = 2'd1,
    REQ_TAKE_OL = 2'd2,
    REQ_PEEK_NR = 2'd3
  } req_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_MAX_ENTRIES = 1'b0,
    CFG_TOLERANCE   = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP,
    ST_SCAN,
    ST_DECIDE,
    ST_WRITE,
    ST_REPLY
  } state_e;

  // One queued frame record
  typedef struct packed {
    logic [HandleBits-1:0] handle;
    logic [SeqBits-1:0]    seq;
    logic [TimeBits-1:0]   ftime;
  } entry_t;

  // Cell control from the sequencer
  typedef struct packed {
    logic rotate;
    logic load;
  } cell_ctrl_t;

  function automatic logic [TimeBits-1:0] abs_diff(input logic [TimeBits-1:0] a,
                                                   input logic [TimeBits-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

@@ rtl/nearest_timestamp_frame_queue.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Signals                          Content
// s_axis   in         s_tvalid/s_tready/s_tdata/tuser  one request
// m_axis   out        m_tvalid/m_tready/m_tdata/tuser  one result per request
// cfg      in         cfg_valid/cfg_ready/index/data   register write
//
// Entries sit oldest first in a ring of DEPTH cells; all cells rotate together.
// After the accepting idle cycle, a push drops oldest entries when full, then
// writes; take-oldest drops the head; a nearest search rotates and compares all
// DEPTH cells, then decides, and a take-nearest drops entries up to the match.
// A rejected push or a request on an empty queue goes straight to the reply.
// Lowering max_entries trims one entry per cycle; no request is taken meanwhile.
// Reset clears count and sequence tracking; cell contents are not reset.
// A result held by m_tready low stalls only the finish of the next request.
module nearest_timestamp_frame_queue
  import ntfq_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [159:0]  s_tdata,   // frame_handle, frame_seq, frame_time, target
  input  logic [1:0]    s_tuser,   // req_type
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [167:0]  m_tdata,   // out_handle, out_seq, out_time, entry_count,
                                   // oldest_time, zero pad
  output logic          m_tuser,   // result_ok
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [47:0]   cfg_data
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] left_q, left_d;
  logic [CW-1:0] scan_q, scan_d;
  logic [CW-1:0] best_pos_q, best_pos_d;
  logic [TimeBits-1:0] best_dist_q, best_dist_d;
  entry_t best_q, best_d;
  logic [SeqBits-1:0] last_seq_q, last_seq_d;
  logic [LimitBits-1:0] limit_q, limit_d;
  logic [TimeBits-1:0] tol_q, tol_d;
  req_e req_q, req_d;
  entry_t in_q, in_d;
  logic [TimeBits-1:0] target_q, target_d;
  logic reply_pend_q, reply_pend_d;
  logic ok_q, ok_d;
  entry_t res_q, res_d;

  logic out_valid_q, out_valid_d;
  logic out_ok_q, out_ok_d;
  logic [167:0] out_data_q, out_data_d;

  cell_ctrl_t ctrl [DEPTH];
  entry_t cells [DEPTH];
  logic rotate;
  logic load;
  logic [CW-1:0] cap;
  logic [CW-1:0] lim_ext;
  logic [TimeBits-1:0] cur_dist;
  logic in_acc, cfg_acc;

  // Cell row: each cell takes its right neighbor, the last wraps to the head
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign ctrl[g].rotate = rotate;
    assign ctrl[g].load   = load && (count_q == CW'(g));
    ntfq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[g]),
      .next_i  (cells[(g + 1) % DEPTH]),
      .load_i  (in_q),
      .entry_o (cells[g])
    );
  end

  assign lim_ext  = (CW > LimitBits) ? CW'(limit_q) : CW'(limit_q);
  assign cap      = ({27'd0, limit_q} > 32'(DEPTH)) ? CW'(DEPTH) : lim_ext;
  assign cur_dist = abs_diff(cells[0].ftime, target_q);
  assign in_acc   = s_tvalid && s_tready;
  assign cfg_acc  = cfg_valid && cfg_ready;

  // Hold off requests while a register write is offered
  assign s_tready  = (state_q == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state_q == ST_IDLE);
  assign m_tvalid  = out_valid_q;
  assign m_tuser   = out_ok_q;
  assign m_tdata   = out_data_q;

  // Sequencer: next state and cell control
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    left_d       = left_q;
    scan_d       = scan_q;
    best_pos_d   = best_pos_q;
    best_dist_d  = best_dist_q;
    best_d       = best_q;
    last_seq_d   = last_seq_q;
    limit_d      = limit_q;
    tol_d        = tol_q;
    req_d        = req_q;
    in_d         = in_q;
    target_d     = target_q;
    reply_pend_d = reply_pend_q;
    ok_d         = ok_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && !m_tready;
    out_ok_d     = out_ok_q;
    out_data_d   = out_data_q;
    rotate       = 1'b0;
    load         = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_acc) begin
          unique case (cfg_e'(cfg_index))
            CFG_MAX_ENTRIES: begin
              limit_d      = cfg_data[LimitBits-1:0];
              left_d       = '0;
              reply_pend_d = 1'b0;
              req_d        = REQ_TAKE_OL;
              state_d      = ST_DROP;
            end
            CFG_TOLERANCE: tol_d = cfg_data[TimeBits-1:0];
            default: ;
          endcase
        end else if (in_acc) begin
          req_d          = req_e'(s_tuser);
          in_d.handle    = s_tdata[31:0];
          in_d.seq       = s_tdata[63:32];
          in_d.ftime     = s_tdata[111:64];
          target_d       = s_tdata[159:112];
          ok_d           = 1'b0;
          res_d          = '0;
          reply_pend_d   = 1'b1;
          left_d         = '0;
          scan_d         = '0;
          unique case (req_e'(s_tuser))
            REQ_PUSH: begin
              if (cap != '0 && s_tdata[63:32] != '0 && s_tdata[63:32] > last_seq_q) begin
                ok_d    = 1'b1;
                left_d  = (count_q >= cap) ? CW'(count_q - cap + CW'(1)) : '0;
                state_d = ST_DROP;
              end else begin
                state_d = ST_REPLY;
              end
            end
            REQ_TAKE_OL: begin
              if (count_q != '0) begin
                ok_d    = 1'b1;
                res_d   = cells[0];
                left_d  = CW'(1);
                state_d = ST_DROP;
              end else begin
                state_d = ST_REPLY;
              end
            end
            default: begin
              state_d = (count_q != '0) ? ST_SCAN : ST_REPLY;
            end
          endcase
        end
      end

      ST_DROP: begin
        // Trim after a lower limit: count the excess on the first cycle
        if (!reply_pend_q && left_q == '0 && count_q > cap) begin
          left_d = CW'(count_q - cap);
        end else if (left_q != '0) begin
          rotate  = 1'b1;
          count_d = count_q - CW'(1);
          left_d  = left_q - CW'(1);
        end else if (!reply_pend_q) begin
          state_d = ST_IDLE;
        end else if (req_q == REQ_PUSH) begin
          state_d = ST_WRITE;
        end else begin
          state_d = ST_REPLY;
        end
      end

      ST_SCAN: begin
        // Compare the head cell, then rotate; DEPTH rotations restore order
        rotate = 1'b1;
        if (scan_q < count_q && (scan_q == '0 || cur_dist < best_dist_q)) begin
          best_dist_d = cur_dist;
          best_pos_d  = scan_q;
          best_d      = cells[0];
        end
        scan_d = scan_q + CW'(1);
        if (scan_q == CW'(DEPTH - 1)) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        res_d.ftime = best_q.ftime;
        if (req_q == REQ_PEEK_NR || best_dist_q <= tol_q) begin
          ok_d  = 1'b1;
          res_d = best_q;
        end
        if (req_q == REQ_TAKE_NR && best_dist_q <= tol_q) begin
          left_d  = best_pos_q + CW'(1);
          state_d = ST_DROP;
        end else begin
          state_d = ST_REPLY;
        end
      end

      ST_WRITE: begin
        load       = 1'b1;
        count_d    = count_q + CW'(1);
        last_seq_d = in_q.seq;
        state_d    = ST_REPLY;
      end

      ST_REPLY: begin
        if (!out_valid_q || m_tready) begin
          out_valid_d  = 1'b1;
          out_ok_d     = ok_q;
          out_data_d   = {3'd0,
                          (count_q != '0) ? cells[0].ftime : {TimeBits{1'b0}},
                          LimitBits'(count_q),
                          res_q.ftime, res_q.seq, res_q.handle};
          reply_pend_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      left_q       <= '0;
      scan_q       <= '0;
      last_seq_q   <= '0;
      limit_q      <= LimitReset;
      tol_q        <= TolReset;
      reply_pend_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      left_q       <= left_d;
      scan_q       <= scan_d;
      last_seq_q   <= last_seq_d;
      limit_q      <= limit_d;
      tol_q        <= tol_d;
      reply_pend_q <= reply_pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    best_pos_q  <= best_pos_d;
    best_dist_q <= best_dist_d;
    best_q      <= best_d;
    req_q       <= req_d;
    in_q        <= in_d;
    target_q    <= target_d;
    ok_q        <= ok_d;
    res_q       <= res_d;
    out_ok_q    <= out_ok_d;
    out_data_q  <= out_data_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ST_IDLE)
    else $error("request accepted without leaving idle");

  a_scan_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |=> $stable(count_q))
    else $error("entry count changed during search");

endmodule

@@ rtl/ntfq_cell.sv @@
`timescale 1ns / 1ps
module ntfq_cell
  import ntfq_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     next_i,
  input  entry_t     load_i,
  output entry_t     entry_o
);

  entry_t entry_q;
  entry_t entry_d;

  // Take the neighbor's record on a rotate, or the new record on a load
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.rotate) begin
      entry_d = next_i;
    end else if (ctrl_i.load) begin
      entry_d = load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
